>>> rtl/vecal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vecal_pkg: shared types, constants and tables
// Widths, Q2.30 angle constants, CORDIC arctangent table and pipeline control
// bundle for the vector angle and length block.
// ----------------------------------------------------------------------------
package vecal_pkg;

  // Field geometry
  localparam int COORD_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int LEN_W           = 17;
  localparam int DIR_W           = 16;

  // Difference and magnitude widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int MAG_W  = COORD_BITS + 1;
  localparam int MSB_W  = $clog2(MAG_W);

  // Length datapath: squares, radicand, digit-by-digit root
  localparam int SQ_W       = 2 * MAG_W;
  localparam int N_W        = 2 * MAG_W;
  localparam int ROOT_W     = MAG_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int LEN_CALC_W = (ROOT_W + 1 > LEN_W) ? ROOT_W + 1 : LEN_W;

  // CORDIC datapath: larger magnitude normalized so its MSB sits at NORM_BIT
  localparam int CORDIC_STEPS = 31;
  localparam int ATAN_IDX_W   = $clog2(CORDIC_STEPS);
  localparam int NORM_BIT     = 40;
  localparam int NORM_W       = NORM_BIT + 1;
  localparam int SHIFT_W      = $clog2(NORM_BIT + 1);
  localparam int XY_W         = NORM_BIT + 5;   // sign plus CORDIC gain headroom
  localparam int Z_W          = 34;
  localparam int PIPE_STAGES  = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

  // Angle arithmetic in Q2.30, rounded to Q3.ANGLE_FRAC_BITS
  localparam int     ANG_W     = 35;
  localparam int     RND_SH    = 30 - ANGLE_FRAC_BITS;
  localparam longint Z_PI      = 64'sd3373259426;
  localparam longint Z_HALF_PI = 64'sd1686629713;
  localparam longint Z_TWO_PI  = 64'sd6746518852;
  localparam longint Z_RND     = 64'sd1 <<< (RND_SH - 1);
  localparam longint DIR_PI_L     = (Z_PI + Z_RND) >>> RND_SH;
  localparam longint DIR_TWO_PI_L = (Z_TWO_PI + Z_RND) >>> RND_SH;

  localparam logic signed [ANG_W-1:0] A_PI         = ANG_W'(Z_PI);
  localparam logic signed [ANG_W-1:0] A_HALF_PI    = ANG_W'(Z_HALF_PI);
  localparam logic signed [ANG_W-1:0] A_TWO_PI     = ANG_W'(Z_TWO_PI);
  localparam logic signed [ANG_W-1:0] A_RND        = ANG_W'(Z_RND);
  localparam logic signed [ANG_W-1:0] A_DIR_PI     = ANG_W'(DIR_PI_L);
  localparam logic signed [ANG_W-1:0] A_DIR_TWO_PI = ANG_W'(DIR_TWO_PI_L);

  // Per-transaction control flags that ride along the pipeline
  typedef struct packed {
    logic degen;    // both differences zero
    logic u_zero;   // horizontal difference zero
    logic v_zero;   // vertical difference zero
    logic swap;     // |v| > |u|, CORDIC ran on swapped operands
    logic u_neg;
    logic v_neg;
  } ctl_t;

  // atan(2^-i) in Q2.30
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    case (idx)
      5'd0:    atan_q30 = Z_W'(32'h3243F6A8);
      5'd1:    atan_q30 = Z_W'(32'h1DAC6705);
      5'd2:    atan_q30 = Z_W'(32'h0FADBAFC);
      5'd3:    atan_q30 = Z_W'(32'h07F56EA6);
      5'd4:    atan_q30 = Z_W'(32'h03FEAB76);
      5'd5:    atan_q30 = Z_W'(32'h01FFD55B);
      5'd6:    atan_q30 = Z_W'(32'h00FFFAAA);
      5'd7:    atan_q30 = Z_W'(32'h007FFF55);
      5'd8:    atan_q30 = Z_W'(32'h003FFFEA);
      5'd9:    atan_q30 = Z_W'(32'h001FFFFD);
      5'd10:   atan_q30 = Z_W'(32'h000FFFFF);
      5'd11:   atan_q30 = Z_W'(32'h0007FFFF);
      5'd12:   atan_q30 = Z_W'(32'h0003FFFF);
      5'd13:   atan_q30 = Z_W'(32'h0001FFFF);
      5'd14:   atan_q30 = Z_W'(32'h0000FFFF);
      5'd15:   atan_q30 = Z_W'(32'h00007FFF);
      5'd16:   atan_q30 = Z_W'(32'h00003FFF);
      5'd17:   atan_q30 = Z_W'(32'h00001FFF);
      5'd18:   atan_q30 = Z_W'(32'h00000FFF);
      5'd19:   atan_q30 = Z_W'(32'h000007FF);
      5'd20:   atan_q30 = Z_W'(32'h000003FF);
      5'd21:   atan_q30 = Z_W'(32'h000001FF);
      5'd22:   atan_q30 = Z_W'(32'h000000FF);
      5'd23:   atan_q30 = Z_W'(32'h0000007F);
      5'd24:   atan_q30 = Z_W'(32'h0000003F);
      5'd25:   atan_q30 = Z_W'(32'h0000001F);
      5'd26:   atan_q30 = Z_W'(32'h0000000F);
      5'd27:   atan_q30 = Z_W'(32'h00000008);
      5'd28:   atan_q30 = Z_W'(32'h00000004);
      5'd29:   atan_q30 = Z_W'(32'h00000002);
      5'd30:   atan_q30 = Z_W'(32'h00000001);
      default: atan_q30 = '0;
    endcase
  endfunction

  // Position of the highest set bit (0 for a zero word)
  function automatic logic [MSB_W-1:0] msb_pos(input logic [MAG_W-1:0] val);
    logic [MSB_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (val[i]) begin
        pos = MSB_W'(i);
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

>>> rtl/vector_angle_and_length_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vector_angle_and_length_top: pipelined vector direction and length
// Takes a start and an end point, returns the rounded Euclidean length of the
// difference vector and its direction in Q3.12 radians (y grows downward).
//
// Usage:
//  - Input: a transaction is taken at every rising edge with start high and
//    busy low. busy is always low, so one point pair enters per cycle.
//  - Output: out_valid pulses for one cycle with out_length, out_direction
//    and out_degenerate. The receiver has no back-pressure; results must be
//    captured in the strobe cycle.
//  - Pipeline: each accepted transaction passes through the input
//    register, magnitude, normalize/square, radicand sum, 31 CORDIC stages,
//    angle select, angle fold and round/output register. Throughput is one
//    transaction per cycle; the 31-stage CORDIC vectoring pipeline and the
//    17-stage root pipeline beside it set the depth.
//  - cfg_wr_en/cfg_wr_data write the angle range mode (0: [0, 2*pi),
//    1: (-pi, pi]); write it only while no transaction is in flight.
//  - Reset (rst_n low, synchronous) clears the mode and all stage valids;
//    transactions in flight are dropped.
// ----------------------------------------------------------------------------
module vector_angle_and_length_top (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // input channel
  input  logic                                        start,
  output logic                                        busy,
  input  logic signed [vecal_pkg::COORD_BITS-1:0]     in_start_x,
  input  logic signed [vecal_pkg::COORD_BITS-1:0]     in_start_y,
  input  logic signed [vecal_pkg::COORD_BITS-1:0]     in_end_x,
  input  logic signed [vecal_pkg::COORD_BITS-1:0]     in_end_y,
  // configuration
  input  logic                                        cfg_wr_en,
  input  logic                                        cfg_wr_data,
  // result channel
  output logic                                        out_valid,
  output logic        [vecal_pkg::LEN_W-1:0]          out_length,
  output logic signed [vecal_pkg::DIR_W-1:0]          out_direction,
  output logic                                        out_degenerate
);
  import vecal_pkg::*;

  localparam int LAST    = PIPE_STAGES - 1;
  localparam int LATENCY = PIPE_STAGES + 6;

  logic in_fire;
  assign busy    = 1'b0;
  assign in_fire = start & ~busy;

  // Mode register
  logic mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Stage 0: differences (u to the right, v upward)
  logic                     s0_vld_r;
  logic signed [DIFF_W-1:0] s0_u_r, s0_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_fire;
    end
  end
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_u_r <= DIFF_W'(in_end_x) - DIFF_W'(in_start_x);
      s0_v_r <= DIFF_W'(in_start_y) - DIFF_W'(in_end_y);
    end
  end

  // Stage 1: magnitudes and signs
  logic             s1_vld_r;
  logic [MAG_W-1:0] s1_mu_r, s1_mv_r;
  logic             s1_uneg_r, s1_vneg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (s0_vld_r) begin
      s1_mu_r   <= MAG_W'(s0_u_r[DIFF_W-1] ? -s0_u_r : s0_u_r);
      s1_mv_r   <= MAG_W'(s0_v_r[DIFF_W-1] ? -s0_v_r : s0_v_r);
      s1_uneg_r <= s0_u_r[DIFF_W-1];
      s1_vneg_r <= s0_v_r[DIFF_W-1];
    end
  end

  // Stage 2: order operands, normalize, square
  logic               s2_swap;
  logic [MAG_W-1:0]   s2_big, s2_small;
  logic [SHIFT_W-1:0] s2_shamt;
  ctl_t               s2_ctl;
  always_comb begin
    s2_swap  = s1_mv_r > s1_mu_r;
    s2_big   = s2_swap ? s1_mv_r : s1_mu_r;
    s2_small = s2_swap ? s1_mu_r : s1_mv_r;
    s2_shamt = SHIFT_W'(NORM_BIT) - SHIFT_W'(msb_pos(s2_big));
    s2_ctl.degen  = (s1_mu_r == '0) && (s1_mv_r == '0);
    s2_ctl.u_zero = (s1_mu_r == '0);
    s2_ctl.v_zero = (s1_mv_r == '0);
    s2_ctl.swap   = s2_swap;
    s2_ctl.u_neg  = s1_uneg_r;
    s2_ctl.v_neg  = s1_vneg_r;
  end

  logic              s2_vld_r;
  logic [NORM_W-1:0] s2_x_r, s2_y_r;
  logic [SQ_W-1:0]   s2_usq_r, s2_vsq_r;
  ctl_t              s2_ctl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_x_r   <= NORM_W'(s2_big) << s2_shamt;
      s2_y_r   <= NORM_W'(s2_small) << s2_shamt;
      s2_usq_r <= SQ_W'(s1_mu_r) * SQ_W'(s1_mu_r);
      s2_vsq_r <= SQ_W'(s1_mv_r) * SQ_W'(s1_mv_r);
      s2_ctl_r <= s2_ctl;
    end
  end

  // Stage 3: radicand sum, CORDIC operands widened to signed
  logic                   s3_vld_r;
  logic signed [XY_W-1:0] s3_x_r, s3_y_r;
  logic [N_W-1:0]         s3_n_r;
  ctl_t                   s3_ctl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      s3_x_r   <= XY_W'(s2_x_r);
      s3_y_r   <= XY_W'(s2_y_r);
      s3_n_r   <= N_W'(s2_usq_r) + N_W'(s2_vsq_r);
      s3_ctl_r <= s2_ctl_r;
    end
  end

  // CORDIC vectoring and root digit pipeline, one step per stage
  logic                   pp_vld_r [PIPE_STAGES];
  logic signed [XY_W-1:0] pp_x_r   [PIPE_STAGES];
  logic signed [XY_W-1:0] pp_y_r   [PIPE_STAGES];
  logic signed [Z_W-1:0]  pp_z_r   [PIPE_STAGES];
  logic [ROOT_W-1:0]      pp_q_r   [PIPE_STAGES];
  logic [REM_W-1:0]       pp_rem_r [PIPE_STAGES];
  logic [N_W-1:0]         pp_n_r   [PIPE_STAGES];
  ctl_t                   pp_ctl_r [PIPE_STAGES];

  for (genvar p = 0; p < PIPE_STAGES; p++) begin : g_pipe
    logic                   vld_in;
    logic signed [XY_W-1:0] x_in, y_in, x_nxt, y_nxt;
    logic signed [Z_W-1:0]  z_in, z_nxt;
    logic [ROOT_W-1:0]      q_in, q_nxt;
    logic [REM_W-1:0]       rem_in, rem_nxt;
    logic [N_W-1:0]         n_in, n_nxt;
    ctl_t                   ctl_in;

    if (p == 0) begin : g_first
      assign vld_in = s3_vld_r;
      assign x_in   = s3_x_r;
      assign y_in   = s3_y_r;
      assign z_in   = '0;
      assign q_in   = '0;
      assign rem_in = '0;
      assign n_in   = s3_n_r;
      assign ctl_in = s3_ctl_r;
    end else begin : g_next
      assign vld_in = pp_vld_r[p-1];
      assign x_in   = pp_x_r[p-1];
      assign y_in   = pp_y_r[p-1];
      assign z_in   = pp_z_r[p-1];
      assign q_in   = pp_q_r[p-1];
      assign rem_in = pp_rem_r[p-1];
      assign n_in   = pp_n_r[p-1];
      assign ctl_in = pp_ctl_r[p-1];
    end

    // Rotation toward the x axis
    if (p < CORDIC_STEPS) begin : g_rot
      always_comb begin
        if (!y_in[XY_W-1]) begin
          x_nxt = x_in + (y_in >>> p);
          y_nxt = y_in - (x_in >>> p);
          z_nxt = z_in + atan_q30(ATAN_IDX_W'(p));
        end else begin
          x_nxt = x_in - (y_in >>> p);
          y_nxt = y_in + (x_in >>> p);
          z_nxt = z_in - atan_q30(ATAN_IDX_W'(p));
        end
      end
    end else begin : g_rot_hold
      assign x_nxt = x_in;
      assign y_nxt = y_in;
      assign z_nxt = z_in;
    end

    // Restoring square root, two radicand bits per stage
    if (p < SQRT_STEPS) begin : g_sqrt
      logic [REM_W+1:0] rs, trial;
      always_comb begin
        rs    = {rem_in, n_in[N_W-1 -: 2]};
        trial = (REM_W + 2)'({q_in, 2'b01});
        if (rs >= trial) begin
          rem_nxt = REM_W'(rs - trial);
          q_nxt   = {q_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt = REM_W'(rs);
          q_nxt   = {q_in[ROOT_W-2:0], 1'b0};
        end
        n_nxt = {n_in[N_W-3:0], 2'b00};
      end
    end else begin : g_sqrt_hold
      assign rem_nxt = rem_in;
      assign q_nxt   = q_in;
      assign n_nxt   = n_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pp_vld_r[p] <= 1'b0;
      end else begin
        pp_vld_r[p] <= vld_in;
      end
    end
    always_ff @(posedge clk) begin
      if (vld_in) begin
        pp_x_r[p]   <= x_nxt;
        pp_y_r[p]   <= y_nxt;
        pp_z_r[p]   <= z_nxt;
        pp_q_r[p]   <= q_nxt;
        pp_rem_r[p] <= rem_nxt;
        pp_n_r[p]   <= n_nxt;
        pp_ctl_r[p] <= ctl_in;
      end
    end
  end

  // Stage A: first-quadrant angle, rounded length
  logic signed [ANG_W-1:0] sa_phi;
  logic [LEN_CALC_W-1:0]   sa_len;
  ctl_t                    la_ctl;
  always_comb begin
    la_ctl = pp_ctl_r[LAST];
    if (la_ctl.v_zero) begin
      sa_phi = '0;
    end else if (la_ctl.u_zero) begin
      sa_phi = A_HALF_PI;
    end else if (la_ctl.swap) begin
      sa_phi = A_HALF_PI - ANG_W'(pp_z_r[LAST]);
    end else begin
      sa_phi = ANG_W'(pp_z_r[LAST]);
    end
    // round half up: remainder above the root means N > q*(q+1)
    sa_len = LEN_CALC_W'(pp_q_r[LAST])
           + LEN_CALC_W'(pp_rem_r[LAST] > REM_W'(pp_q_r[LAST]));
  end

  logic                    sa_vld_r;
  logic signed [ANG_W-1:0] sa_phi_r;
  logic [LEN_W-1:0]        sa_len_r;
  ctl_t                    sa_ctl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
    end else begin
      sa_vld_r <= pp_vld_r[LAST];
    end
  end
  always_ff @(posedge clk) begin
    if (pp_vld_r[LAST]) begin
      sa_phi_r <= sa_phi;
      sa_len_r <= sa_len[LEN_W-1:0];
      sa_ctl_r <= la_ctl;
    end
  end

  // Stage B: fold into the full circle per quadrant and mode
  logic signed [ANG_W-1:0] sb_ang;
  always_comb begin
    if (!sa_ctl_r.v_neg) begin
      sb_ang = sa_ctl_r.u_neg ? A_PI - sa_phi_r : sa_phi_r;
    end else if (mode_r) begin
      sb_ang = sa_ctl_r.u_neg ? sa_phi_r - A_PI : -sa_phi_r;
    end else begin
      sb_ang = sa_ctl_r.u_neg ? A_PI + sa_phi_r : A_TWO_PI - sa_phi_r;
    end
  end

  logic                    sb_vld_r;
  logic signed [ANG_W-1:0] sb_ang_r;
  logic [LEN_W-1:0]        sb_len_r;
  logic                    sb_degen_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r <= 1'b0;
    end else begin
      sb_vld_r <= sa_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (sa_vld_r) begin
      sb_ang_r   <= sb_ang;
      sb_len_r   <= sa_len_r;
      sb_degen_r <= sa_ctl_r.degen;
    end
  end

  // Stage C: round to output format, wrap at the range ends
  logic signed [ANG_W-1:0] sc_rnd, sc_dir;
  always_comb begin
    sc_rnd = (sb_ang_r + A_RND) >>> RND_SH;
    if (sb_degen_r) begin
      sc_dir = '0;
    end else if (!mode_r && sc_rnd == A_DIR_TWO_PI) begin
      sc_dir = '0;
    end else if (mode_r && sc_rnd == -A_DIR_PI) begin
      sc_dir = A_DIR_PI;
    end else begin
      sc_dir = sc_rnd;
    end
  end

  logic                    out_valid_r;
  logic [LEN_W-1:0]        out_length_r;
  logic signed [DIR_W-1:0] out_direction_r;
  logic                    out_degenerate_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sb_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (sb_vld_r) begin
      out_length_r     <= sb_len_r;
      out_direction_r  <= DIR_W'(sc_dir);
      out_degenerate_r <= sb_degen_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_length     = out_length_r;
  assign out_direction  = out_direction_r;
  assign out_degenerate = out_degenerate_r;

  // Checks
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_degenerate_r |-> out_direction_r == '0 && out_length_r == '0)
    else $error("degenerate transaction with nonzero length or direction");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_degenerate_r |-> out_length_r != '0)
    else $error("nonzero vector produced zero length");

  a_mode1_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && mode_r |->
      ANG_W'(out_direction_r) <= A_DIR_PI && ANG_W'(out_direction_r) > -A_DIR_PI)
    else $error("direction outside (-pi, pi]");

  a_mode0_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !mode_r |->
      ANG_W'(out_direction_r) >= 0 && ANG_W'(out_direction_r) < A_DIR_TWO_PI)
    else $error("direction outside [0, 2*pi)");

  // s0 valid to out valid crosses LATENCY registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(s0_vld_r, LATENCY))
    else $error("result strobe without matching transaction");

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for vector_angle_and_length_top
// Sends point pairs through the command-style input and predicts, for each
// accepted pair, the rounded length and the CORDIC direction of the vector
// in the angle range mode in force. Every strobed result is checked in order.
// The run has four phases that alternate the range mode. Each has a directed
// or random mix of axis, diagonal, coincident, extreme and wrap-around
// vectors, with random gaps and zero-gap bursts on the input side.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 45;
  localparam int RANDOM_PER_PHASE = 330;
  localparam int MAX_REPORTS      = 10;

  // Angle constants in Q2.30 and the rounding to the Q3.12 output
  localparam int     OUT_SHIFT   = 30 - vecal_pkg::ANGLE_FRAC_BITS;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint HALF_LSB    = 64'sd1 <<< (OUT_SHIFT - 1);
  localparam longint DIR_PI      = (PI_Q30 + HALF_LSB) >>> OUT_SHIFT;
  localparam longint DIR_TWO_PI  = (TWO_PI_Q30 + HALF_LSB) >>> OUT_SHIFT;
  localparam int     ROT_STEPS   = 31;
  localparam longint NORM_FLOOR  = 64'sd1 <<< 40;

  // atan(2^-i) in Q2.30
  localparam longint ATAN_STEP [ROT_STEPS] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001
  };

  typedef logic signed [vecal_pkg::COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    int     gap;
  } point_pair_t;

  typedef struct {
    logic        [vecal_pkg::LEN_W-1:0] length;
    logic signed [vecal_pkg::DIR_W-1:0] direction;
    logic                               degenerate;
  } polar_t;

  // DUT connections, all inputs known from time zero
  logic   clk            = 1'b0;
  logic   rst_n          = 1'b0;
  logic   start          = 1'b0;
  coord_t in_start_x     = '0;
  coord_t in_start_y     = '0;
  coord_t in_end_x       = '0;
  coord_t in_end_y       = '0;
  logic   cfg_wr_en      = 1'b0;
  logic   cfg_wr_data    = 1'b0;
  logic   busy;
  logic   out_valid;
  logic   [vecal_pkg::LEN_W-1:0] out_length;
  logic   signed [vecal_pkg::DIR_W-1:0] out_direction;
  logic   out_degenerate;

  // Bench state
  point_pair_t pending_pairs[$];
  polar_t      expected_polar[$];
  polar_t      want;
  point_pair_t cur_pair;
  logic        range_mode   = 1'b0;
  logic        taken_q      = 1'b0;
  int          idle_left    = 0;
  int          n_queued     = 0;
  int          n_accepted   = 0;
  int          n_checked    = 0;
  int          n_degenerate = 0;
  int          n_errors     = 0;
  int          cycle_count  = 0;

  vector_angle_and_length_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_length     (out_length),
    .out_direction  (out_direction),
    .out_degenerate (out_degenerate)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Rounded integer square root; an exact half cannot occur for integers
  function automatic longint rounded_root(input longint n);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'sd1 <<< 18;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (mid * mid <= n) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    if (n > lo * (lo + 1)) begin
      lo++;
    end
    return lo;
  endfunction

  // First-octant angle of (big, lesser) in Q2.30, big >= lesser >= 0
  function automatic longint octant_angle(input longint big, input longint lesser);
    longint x, y, z, xs, ys;
    x = big;
    y = lesser;
    z = 0;
    while (x < NORM_FLOOR) begin
      x = x <<< 1;
      y = y <<< 1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += ATAN_STEP[i];
      end else begin
        x -= ys;
        y += xs;
        z -= ATAN_STEP[i];
      end
    end
    return z;
  endfunction

  // Length and screen direction of the vector from start to end point
  function automatic polar_t polar_of(input coord_t sx, input coord_t sy,
                                      input coord_t ex, input coord_t ey,
                                      input logic mode);
    polar_t r;
    longint u, v, mag_u, mag_v, phi, a, ang, dir;
    u = longint'(ex) - longint'(sx);
    v = longint'(sy) - longint'(ey);      // y grows downward
    mag_u = (u < 0) ? -u : u;
    mag_v = (v < 0) ? -v : v;
    if (mag_u == 0 && mag_v == 0) begin
      r.length = '0;
      r.direction = '0;
      r.degenerate = 1'b1;
      return r;
    end
    if (mag_v == 0) begin
      phi = 0;
    end else if (mag_u == 0) begin
      phi = HALF_PI_Q30;
    end else if (mag_v > mag_u) begin
      phi = HALF_PI_Q30 - octant_angle(mag_v, mag_u);
    end else begin
      phi = octant_angle(mag_u, mag_v);
    end
    a = (u >= 0) ? phi : PI_Q30 - phi;
    if (v < 0) begin
      ang = mode ? -a : TWO_PI_Q30 - a;
    end else begin
      ang = a;
    end
    dir = (ang + HALF_LSB) >>> OUT_SHIFT;
    // fold the rounded full turn and the rounded lower bound of (-pi, pi]
    if (!mode && dir == DIR_TWO_PI) begin
      dir = 0;
    end
    if (mode && dir == -DIR_PI) begin
      dir = DIR_PI;
    end
    r.length = vecal_pkg::LEN_W'(rounded_root(mag_u * mag_u + mag_v * mag_v));
    r.direction = vecal_pkg::DIR_W'(dir);
    r.degenerate = 1'b0;
    return r;
  endfunction

  task automatic add_pair(input int sx, input int sy, input int ex, input int ey,
                          input int gap);
    point_pair_t p;
    p.sx = coord_t'(sx);
    p.sy = coord_t'(sy);
    p.ex = coord_t'(ex);
    p.ey = coord_t'(ey);
    p.gap = gap;
    pending_pairs.push_back(p);
    n_queued++;
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic int pick_extreme();
    int vals [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    return vals[$urandom_range(0, 6)];
  endfunction

  // Corners, axes, coincident points and vectors just beside the wrap points
  task automatic add_directed_set();
    add_pair(0, 0, 0, 0, 0);
    add_pair(-32768, -32768, -32768, -32768, 0);
    add_pair(32767, 32767, 32767, 32767, draw_gap());
    add_pair(-32768, -32768, 32767, 32767, 0);
    add_pair(32767, 32767, -32768, -32768, 0);
    add_pair(-32768, 32767, 32767, -32768, draw_gap());
    add_pair(32767, -32768, -32768, 32767, 0);
    add_pair(0, 0, 100, 0, 0);
    add_pair(0, 0, -100, 0, draw_gap());
    add_pair(0, 0, 0, 100, 0);
    add_pair(0, 0, 0, -100, 0);
    add_pair(-32768, 0, 32767, 1, draw_gap());
    add_pair(32767, 0, -32768, 1, 0);
    add_pair(32767, 1, -32768, 0, 0);
    add_pair(0, 0, 1, 1, draw_gap());
    add_pair(0, 0, 1, -2, 0);
    add_pair(0, 0, -2, 1, 0);
    add_pair(5, 7, 8, 3, draw_gap());
    add_pair(0, 0, 1, 0, 0);
    add_pair(0, 0, 32767, -32768, 0);
    add_pair(-1, -1, 0, 0, draw_gap());
    add_pair(0, 0, -32768, -32768, 0);
  endtask

  task automatic add_random_pair(input int gap);
    int sx, sy, ex, ey, d;
    sx = int'(coord_t'($urandom));
    sy = int'(coord_t'($urandom));
    ex = int'(coord_t'($urandom));
    ey = int'(coord_t'($urandom));
    case ($urandom_range(0, 9))
      3, 4: begin   // short vector
        sx = int'($urandom_range(0, 64000)) - 32000;
        sy = int'($urandom_range(0, 64000)) - 32000;
        ex = sx + int'($urandom_range(0, 80)) - 40;
        ey = sy + int'($urandom_range(0, 80)) - 40;
      end
      5: begin      // axis aligned
        if ($urandom_range(0, 1)) begin
          ex = sx;
        end else begin
          ey = sy;
        end
      end
      6: begin      // coincident
        ex = sx;
        ey = sy;
      end
      7: begin      // exact diagonal
        sx = int'($urandom_range(0, 32767)) - 16384;
        sy = int'($urandom_range(0, 32767)) - 16384;
        d = int'($urandom_range(1, 16000));
        ex = $urandom_range(0, 1) ? sx + d : sx - d;
        ey = $urandom_range(0, 1) ? sy + d : sy - d;
      end
      8: begin      // extreme coordinates
        sx = pick_extreme();
        sy = pick_extreme();
        ex = pick_extreme();
        ey = pick_extreme();
      end
      9: begin      // near an axis, long vector
        sx = $urandom_range(0, 1) ? -32768 : 32767;
        ex = -sx - 1;
        sy = int'($urandom_range(0, 60000)) - 30000;
        ey = sy + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) begin
          {sx, sy} = {sy, sx};
          {ex, ey} = {ey, ex};
        end
      end
      default: ;    // fully random points
    endcase
    add_pair(sx, sy, ex, ey, gap);
  endtask

  // Wait until every queued pair is accepted and answered, then let it settle
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (n_accepted != n_queued || expected_polar.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_range_mode(input logic mode);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Driver: one pair per transaction, holds start until taken, then idles
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !taken_q) begin
      // keep presenting the current pair
    end else if (idle_left > 0) begin
      start <= 1'b0;
      idle_left <= idle_left - 1;
    end else if (pending_pairs.size() > 0) begin
      cur_pair = pending_pairs.pop_front();
      in_start_x <= cur_pair.sx;
      in_start_y <= cur_pair.sy;
      in_end_x   <= cur_pair.ex;
      in_end_y   <= cur_pair.ey;
      start      <= 1'b1;
      idle_left  <= cur_pair.gap;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: predict on acceptance, check each strobed result in order
  always @(posedge clk) begin
    if (!rst_n) begin
      taken_q    <= 1'b0;
      range_mode <= 1'b0;
    end else begin
      taken_q <= start && !busy;
      if (start && !busy) begin
        want = polar_of(in_start_x, in_start_y, in_end_x, in_end_y, range_mode);
        if (want.degenerate) begin
          n_degenerate++;
        end
        expected_polar.push_back(want);
        n_accepted++;
      end
      if (out_valid) begin
        if (expected_polar.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("[%0d] unexpected result: length %0d direction %0d degenerate %0b",
                     cycle_count, out_length, out_direction, out_degenerate);
          end
        end else begin
          want = expected_polar.pop_front();
          n_checked++;
          if (out_length !== want.length || out_direction !== want.direction ||
              out_degenerate !== want.degenerate) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("[%0d] mismatch in transaction %0d: length %0d/%0d",
                       cycle_count, n_checked, want.length, out_length);
              $display("    direction %0d/%0d degenerate %0b/%0b (expected/actual)",
                       want.direction, out_direction, want.degenerate, out_degenerate);
            end
          end
        end
      end
      if (cfg_wr_en) begin
        range_mode <= cfg_wr_data;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, expected_polar.size());
      $display("FAIL vector_angle_and_length_top");
      $finish;
    end
  end

  // Sequence: reset, then four phases alternating the range mode
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_range_mode(ph[0]);
      end
      if (ph < 2) begin
        add_directed_set();
      end
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        add_random_pair((k % 100 < 25) ? 0 : draw_gap());
      end
    end
    wait_idle();
    $display("Checked %0d transactions (%0d with coincident points) in 4 phases,",
             n_checked, n_degenerate);
    $display("both angle ranges; %0d errors, %0d results left unanswered",
             n_errors, expected_polar.size());
    if (n_errors == 0 && expected_polar.size() == 0) begin
      $display("PASS vector_angle_and_length_top");
    end else begin
      $display("FAIL vector_angle_and_length_top");
    end
    $finish;
  end

endmodule
